[rtl/assert_macros.svh]
// Assertion macros for the rainbow color map RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define PR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define PR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/prainbow_pkg.sv]
// Package for the rainbow color map: widths, register indexes and constant tables.
`default_nettype none

package prainbow_pkg;

  // Fixed-point format and field widths.
  localparam int FRAC_BITS   = 16;
  localparam int HUE_W       = 17;
  localparam int LEVEL_W     = 16;
  localparam int CFG_W       = 17;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 48;

  // Table geometry. HUE_POINTS sets how many segments the scaled hue wraps over.
  localparam int HUE_POINTS   = 61;
  localparam int HUE_TBL_LEN  = 61;
  localparam int HUE_SCALE    = 40;
  localparam int HUE_SEGS     = (HUE_POINTS - 1 < 1) ? 1 : HUE_POINTS - 1;
  localparam int HUE_IDX_W    = $clog2(HUE_TBL_LEN - 1);
  localparam int SCALED_W     = HUE_W + 6;
  localparam int WHOLE_W      = SCALED_W - FRAC_BITS;
  localparam int WRAP_LEN     = 2 ** WHOLE_W;

  localparam logic [HUE_W-1:0]   ONE       = HUE_W'(1) << FRAC_BITS;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_SATURATION = 1'b0,
    CFG_BRIGHTNESS = 1'b1
  } cfg_reg_t;

  // Hexcone sectors, red through magenta.
  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_t;

  // Perceptual hue table in units of 1/10000.
  localparam int unsigned PERC_HUE [HUE_TBL_LEN] = '{
    0, 62, 130, 202, 280, 365, 457, 559,
    671, 796, 936, 1095, 1275, 1482, 1806, 2113,
    2393, 2652, 2892, 3119, 3333, 3556, 3815, 4129,
    4526, 5060, 5296, 5501, 5679, 5834, 5970, 6088,
    6191, 6281, 6361, 6430, 6490, 6544, 6590, 6631,
    6667, 6713, 6763, 6815, 6873, 6937, 7009, 7092,
    7190, 7308, 7452, 7631, 7856, 8142, 8621, 9029,
    9344, 9580, 9755, 9889, 10000
  };

  typedef logic [HUE_W-1:0]     hue_fix_tbl_t [HUE_TBL_LEN];
  typedef logic [HUE_IDX_W-1:0] wrap_tbl_t    [WRAP_LEN];

  // Hue table converted to fixed point, rounded to nearest.
  function automatic hue_fix_tbl_t build_hue_fix();
    hue_fix_tbl_t tbl;
    longint unsigned e;
    for (int i = 0; i < HUE_TBL_LEN; i++) begin
      e = longint'(PERC_HUE[i]);
      tbl[i] = HUE_W'(((e << FRAC_BITS) + 64'd5000) / 64'd10000);
    end
    return tbl;
  endfunction

  // Whole part of the scaled hue to segment index, wrapped and clamped.
  function automatic wrap_tbl_t build_wrap();
    wrap_tbl_t tbl;
    int w;
    for (int i = 0; i < WRAP_LEN; i++) begin
      w = i % HUE_SEGS;
      if (w > HUE_TBL_LEN - 2) begin
        w = HUE_TBL_LEN - 2;
      end
      tbl[i] = HUE_IDX_W'(w);
    end
    return tbl;
  endfunction

  localparam hue_fix_tbl_t HUE_FIX = build_hue_fix();
  localparam wrap_tbl_t    WRAP    = build_wrap();

endpackage

`default_nettype wire

[rtl/perceptual_rainbow_hsv_to_rgb_core.sv]
// Rainbow color map core: hue code to saturated, value-scaled RGB levels.
//
// Usage:
//   The input channel (in_t*) carries one hue code per beat, 16 fraction
//   bits, 0 red, 1/2 green, 1 blue, up to below 1.5 for magenta; codes
//   beyond that wrap. The output channel (out_t*) carries one RGB beat per
//   input beat, in order. Saturation and brightness are written on the
//   cfg_ port while no beat is in flight; both reset to one.
//   Throughput is one beat per cycle while the output does not stall: a
//   seven-register pipeline with a valid bit per stage, where the widest
//   step is one 17x17 multiply.
//   The whole pipeline advances together. When the receiver stalls with a
//   beat waiting in the output register, in_tready drops and every stage
//   holds; nothing is lost or repeated. While the output register is empty
//   the pipeline keeps moving even if out_tready is low.
//   Reset (rst_n low at a clock edge) empties the pipeline and restores
//   the configuration registers.
`default_nettype none
`include "assert_macros.svh"

module perceptual_rainbow_hsv_to_rgb_core
  import prainbow_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Input beat: [16:0] hue_code, [23:17] zero.
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // Output beat: [15:0] red_level, [31:16] green_level, [47:32] blue_level.
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_addr,
  input  wire logic [CFG_W-1:0]       cfg_wdata
);

  // Configuration registers.
  logic [CFG_W-1:0] saturation_r;
  logic [CFG_W-1:0] brightness_r;

  // Stage valid bits.
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, out_v_r;
  logic advance;

  // Stage payloads.
  logic [WHOLE_W-1:0]   s1_whole_r;
  logic [FRAC_BITS-1:0] s1_frac_r;
  logic [HUE_W-1:0]     s2_lo_r;
  logic [HUE_W-1:0]     s2_diff_r;
  logic [FRAC_BITS-1:0] s2_frac_r;
  logic [HUE_W-1:0]     s3_hue_r;
  sector_t              s4_sector_r;
  logic [FRAC_BITS-1:0] s4_f_r;
  sector_t              s5_sector_r;
  logic [HUE_W-1:0]     s5_m_r, s5_n_r, s5_k_r;
  logic [HUE_W-1:0]     s6_red_r, s6_green_r, s6_blue_r;
  logic [LEVEL_W-1:0]   out_red_r, out_green_r, out_blue_r;

  // Combinational stage results.
  logic [SCALED_W-1:0]      scaled;
  logic [HUE_IDX_W-1:0]     seg_idx;
  logic [HUE_W-1:0]         tbl_lo, tbl_hi;
  logic [HUE_W+FRAC_BITS-1:0] interp_prod;
  logic [HUE_W-1:0]         hue_nxt;
  logic [FRAC_BITS+2:0]     h6;
  logic [HUE_W-1:0]         sat_clamp;
  logic [HUE_W+FRAC_BITS-1:0] sf_prod;
  logic [HUE_W-1:0]         one_minus_f;
  logic [2*HUE_W-1:0]       sk_prod;
  logic [HUE_W-1:0]         red_nxt, green_nxt, blue_nxt;
  logic [2*HUE_W-1:0]       red_prod, green_prod, blue_prod;
  logic [LEVEL_W-1:0]       red_lvl, green_lvl, blue_lvl;

  assign advance   = !out_v_r || out_tready;
  assign in_tready = advance;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      saturation_r <= CFG_W'(ONE);
      brightness_r <= CFG_W'(ONE);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        CFG_SATURATION: saturation_r <= cfg_wdata;
        CFG_BRIGHTNESS: brightness_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Valid bits move with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      s6_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (advance) begin
      s1_v_r  <= in_tvalid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      s5_v_r  <= s4_v_r;
      s6_v_r  <= s5_v_r;
      out_v_r <= s6_v_r;
    end
  end

  // Stage 1: scale the hue by 40 (shift and add).
  assign scaled = (SCALED_W'(in_tdata[HUE_W-1:0]) << 5)
                + (SCALED_W'(in_tdata[HUE_W-1:0]) << 3);

  // Stage 2: wrap into the table and fetch the two neighbors.
  assign seg_idx = WRAP[s1_whole_r];
  assign tbl_lo  = HUE_FIX[seg_idx];
  assign tbl_hi  = HUE_FIX[seg_idx + HUE_IDX_W'(1)];

  // Stage 3: linear interpolation.
  assign interp_prod = s2_diff_r * s2_frac_r;
  assign hue_nxt     = s2_lo_r + interp_prod[HUE_W+FRAC_BITS-1:FRAC_BITS];

  // Stage 4: split the hue into sector and fraction.
  assign h6 = (FRAC_BITS+3)'(s3_hue_r[FRAC_BITS-1:0]) * (FRAC_BITS+3)'(6);

  // Stage 5: hexcone terms m, n and k.
  assign sat_clamp   = (saturation_r > ONE) ? ONE : saturation_r;
  assign sf_prod     = sat_clamp * s4_f_r;
  assign one_minus_f = ONE - HUE_W'(s4_f_r);
  assign sk_prod     = sat_clamp * one_minus_f;

  // Stage 6: sector selects the channel order.
  always_comb begin
    unique case (s5_sector_r)
      SEC_RED: begin
        red_nxt = ONE;      green_nxt = s5_k_r;   blue_nxt = s5_m_r;
      end
      SEC_YELLOW: begin
        red_nxt = s5_n_r;   green_nxt = ONE;      blue_nxt = s5_m_r;
      end
      SEC_GREEN: begin
        red_nxt = s5_m_r;   green_nxt = ONE;      blue_nxt = s5_k_r;
      end
      SEC_CYAN: begin
        red_nxt = s5_m_r;   green_nxt = s5_n_r;   blue_nxt = ONE;
      end
      SEC_BLUE: begin
        red_nxt = s5_k_r;   green_nxt = s5_m_r;   blue_nxt = ONE;
      end
      default: begin
        red_nxt = ONE;      green_nxt = s5_m_r;   blue_nxt = s5_n_r;
      end
    endcase
  end

  // Stage 7: scale by brightness and saturate.
  assign red_prod   = s6_red_r * brightness_r;
  assign green_prod = s6_green_r * brightness_r;
  assign blue_prod  = s6_blue_r * brightness_r;

  assign red_lvl   = (red_prod[2*HUE_W-1:FRAC_BITS+LEVEL_W] != '0) ? LEVEL_MAX
                   : red_prod[FRAC_BITS+LEVEL_W-1:FRAC_BITS];
  assign green_lvl = (green_prod[2*HUE_W-1:FRAC_BITS+LEVEL_W] != '0) ? LEVEL_MAX
                   : green_prod[FRAC_BITS+LEVEL_W-1:FRAC_BITS];
  assign blue_lvl  = (blue_prod[2*HUE_W-1:FRAC_BITS+LEVEL_W] != '0) ? LEVEL_MAX
                   : blue_prod[FRAC_BITS+LEVEL_W-1:FRAC_BITS];

  // Payload registers, all held while the pipeline is stalled.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_whole_r  <= scaled[SCALED_W-1:FRAC_BITS];
      s1_frac_r   <= scaled[FRAC_BITS-1:0];

      s2_lo_r     <= tbl_lo;
      s2_diff_r   <= tbl_hi - tbl_lo;
      s2_frac_r   <= s1_frac_r;

      s3_hue_r    <= hue_nxt;

      s4_sector_r <= sector_t'(h6[FRAC_BITS+2:FRAC_BITS]);
      s4_f_r      <= h6[FRAC_BITS-1:0];

      s5_sector_r <= s4_sector_r;
      s5_m_r      <= ONE - sat_clamp;
      s5_n_r      <= ONE - sf_prod[HUE_W+FRAC_BITS-1:FRAC_BITS];
      s5_k_r      <= ONE - HUE_W'(sk_prod[2*HUE_W-1:FRAC_BITS]);

      s6_red_r    <= red_nxt;
      s6_green_r  <= green_nxt;
      s6_blue_r   <= blue_nxt;

      out_red_r   <= red_lvl;
      out_green_r <= green_lvl;
      out_blue_r  <= blue_lvl;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_blue_r, out_green_r, out_red_r};

  // Interpolated hue never passes the last table entry.
  `PR_ASSERT_NOW(a_hue_bounded, s3_v_r, s3_hue_r <= ONE, "interpolated hue above one")
  // Hue fraction times six stays within the six sectors.
  `PR_ASSERT_NOW(a_sector_range, s4_v_r, s4_sector_r <= SEC_MAGENTA, "sector out of range")
  // The largest component of every selected color is one.
  `PR_ASSERT_NOW(a_max_is_one, s6_v_r,
                 s6_red_r == ONE || s6_green_r == ONE || s6_blue_r == ONE,
                 "no component at full scale")
  // A stalled output beat blocks new input and holds the pipeline.
  `PR_ASSERT_NEXT(a_stall_holds, out_v_r && !out_tready, $stable(s6_v_r) && out_v_r,
                  "pipeline moved during output stall")

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the perceptual rainbow hue-to-RGB core.
`default_nettype none

module tb
  import prainbow_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned UNIT        = 64'd1 << FRAC_BITS;
  localparam longint unsigned FRAC_MASK   = UNIT - 1;
  localparam longint unsigned HUE_GAIN    = 40;
  localparam longint unsigned SEGMENTS    = 60;
  localparam int              CYCLE_LIMIT = 250000;
  localparam int              DRAIN_WAIT  = 16;

  // Perceptual hue knots in units of 1/10000.
  localparam int unsigned HUE_KNOTS [61] = '{
    0, 62, 130, 202, 280, 365, 457, 559,
    671, 796, 936, 1095, 1275, 1482, 1806, 2113,
    2393, 2652, 2892, 3119, 3333, 3556, 3815, 4129,
    4526, 5060, 5296, 5501, 5679, 5834, 5970, 6088,
    6191, 6281, 6361, 6430, 6490, 6544, 6590, 6631,
    6667, 6713, 6763, 6815, 6873, 6937, 7009, 7092,
    7190, 7308, 7452, 7631, 7856, 8142, 8621, 9029,
    9344, 9580, 9755, 9889, 10000
  };

  // Hue codes at the edges of the field, the primaries and the wrap point.
  localparam logic [HUE_W-1:0] EDGE_HUES [20] = '{
    17'd0, 17'd1, 17'd98303, 17'd98304, 17'd131071, 17'd21845, 17'd43691,
    17'd65535, 17'd65536, 17'd8192, 17'd40960, 17'd1638, 17'd1639, 17'd32768,
    17'd81920, 17'd96000, 17'd114688, 17'd24576, 17'd57344, 17'd90112
  };

  // Result beat, red in the lowest bits.
  typedef struct packed {
    logic [LEVEL_W-1:0] blue;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] red;
  } rgb_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_we = 1'b0;
  logic                   cfg_addr = CFG_SATURATION;
  logic [CFG_W-1:0]       cfg_wdata = '0;

  // Shadow copies of the configuration registers.
  logic [CFG_W-1:0] saturation_shadow = CFG_W'(UNIT);
  logic [CFG_W-1:0] brightness_shadow = CFG_W'(UNIT);

  rgb_t pending_rgb [$];
  rgb_t want_rgb;
  rgb_t got_rgb;
  int   idle_pct = 34;
  int   fail_count = 0;
  int   cycle_count = 0;

  perceptual_rainbow_hsv_to_rgb_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Hue knot converted to fixed point, rounded to nearest.
  function automatic longint unsigned knot_fixed(input longint unsigned idx);
    longint unsigned e;
    e = HUE_KNOTS[idx];
    return ((e << FRAC_BITS) + 64'd5000) / 64'd10000;
  endfunction

  // Channel times brightness, truncated and clipped to full scale.
  function automatic logic [LEVEL_W-1:0] scale_channel(input longint unsigned comp,
                                                       input longint unsigned gain);
    longint unsigned p;
    p = (comp * gain) >> FRAC_BITS;
    return (p > 64'd65535) ? LEVEL_MAX : LEVEL_W'(p);
  endfunction

  // Expected RGB levels for one hue code under the given register values.
  function automatic rgb_t rainbow_rgb(input logic [HUE_W-1:0] code,
                                       input logic [CFG_W-1:0] sat_cfg,
                                       input logic [CFG_W-1:0] bright_cfg);
    longint unsigned pos, seg, fr, lo, hi, hue, h6, f, s, m, n, k, r, g, b;
    sector_t sec;
    rgb_t res;
    // Scale by forty and wrap over the sixty segments of the knot table.
    pos = code;
    pos = (pos * HUE_GAIN) % (SEGMENTS << FRAC_BITS);
    seg = pos >> FRAC_BITS;
    fr  = pos & FRAC_MASK;
    if (seg > SEGMENTS - 1) begin
      seg = SEGMENTS - 1;
    end
    lo  = knot_fixed(seg);
    hi  = knot_fixed(seg + 1);
    hue = lo + (((hi - lo) * fr) >> FRAC_BITS);

    // Hexcone terms; saturation above one counts as one.
    h6  = (hue & FRAC_MASK) * 6;
    sec = sector_t'(h6 >> FRAC_BITS);
    f   = h6 & FRAC_MASK;
    s   = (sat_cfg > UNIT) ? UNIT : sat_cfg;
    m   = UNIT - s;
    n   = UNIT - ((s * f) >> FRAC_BITS);
    k   = UNIT - ((s * (UNIT - f)) >> FRAC_BITS);
    case (sec)
      SEC_RED: begin
        r = UNIT; g = k; b = m;
      end
      SEC_YELLOW: begin
        r = n; g = UNIT; b = m;
      end
      SEC_GREEN: begin
        r = m; g = UNIT; b = k;
      end
      SEC_CYAN: begin
        r = m; g = n; b = UNIT;
      end
      SEC_BLUE: begin
        r = k; g = m; b = UNIT;
      end
      default: begin
        r = UNIT; g = m; b = n;
      end
    endcase
    res.red   = scale_channel(r, bright_cfg);
    res.green = scale_channel(g, bright_cfg);
    res.blue  = scale_channel(b, bright_cfg);
    return res;
  endfunction

  // Mostly legal hues, some past the wrap point, some close to a knot.
  function automatic logic [HUE_W-1:0] pick_hue();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) begin
      return HUE_W'($urandom_range(98303, 0));
    end else if (sel < 85) begin
      return HUE_W'($urandom_range(131071, 98304));
    end
    return HUE_W'($urandom_range(59) * 1638 + $urandom_range(3));
  endfunction

  // Register value: extremes now and then, otherwise anywhere in range.
  function automatic logic [CFG_W-1:0] pick_setting();
    int unsigned sel;
    sel = $urandom_range(9);
    case (sel)
      0: return '0;
      1: return CFG_W'(UNIT);
      2: return '1;
      3: return CFG_W'($urandom_range(131071, 65537));
      default: return CFG_W'($urandom_range(65536));
    endcase
  endfunction

  // Send one hue beat, idling first at random, and log its expected colors.
  task automatic send_hue(input logic [HUE_W-1:0] code);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(code);
    do begin
      @(posedge clk);
    end while (!in_tready);
    pending_rgb.push_back(rainbow_rgb(code, saturation_shadow, brightness_shadow));
  endtask

  // Stop sending and wait until every expected beat has come out.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending_rgb.size() != 0);
  endtask

  // Write one register; the caller makes sure the core is idle and drops cfg_we.
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == CFG_SATURATION) begin
      saturation_shadow = val;
    end else begin
      brightness_shadow = val;
    end
  endtask

  task automatic set_color(input logic [CFG_W-1:0] sat_val,
                           input logic [CFG_W-1:0] bright_val);
    wait_idle();
    write_reg(CFG_SATURATION, sat_val);
    write_reg(CFG_BRIGHTNESS, bright_val);
    cfg_we <= 1'b0;
  endtask

  // Edge hues with the reset values of both registers.
  task automatic test_edge_hues();
    foreach (EDGE_HUES[i]) begin
      send_hue(EDGE_HUES[i]);
    end
    wait_idle();
  endtask

  // Extreme register settings, including values above one.
  task automatic test_register_extremes();
    logic [CFG_W-1:0] sat_list [8];
    logic [CFG_W-1:0] bright_list [8];
    sat_list    = '{17'd0, 17'd65536, 17'd131071, 17'd65536, 17'd131071, 17'd1,
                    17'd32768, 17'd65535};
    bright_list = '{17'd65536, 17'd0, 17'd131071, 17'd131071, 17'd65536, 17'd1,
                    17'd49152, 17'd65535};
    foreach (sat_list[i]) begin
      set_color(sat_list[i], bright_list[i]);
      send_hue(17'd0);
      send_hue(17'd131071);
      repeat (6) begin
        send_hue(pick_hue());
      end
    end
    wait_idle();
  endtask

  // Random hues over several register settings; one phase runs without idling.
  task automatic test_random_hues();
    for (int phase = 0; phase < 10; phase++) begin
      set_color(pick_setting(), pick_setting());
      idle_pct = (phase == 4) ? 0 : 34;
      repeat (150) begin
        send_hue(pick_hue());
      end
    end
    wait_idle();
    idle_pct = 34;
  endtask

  // Receiver stalls at random, except while idling is switched off.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= idle_pct);
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_rgb = out_tdata;
      if (pending_rgb.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result beat %h", $time, out_tdata);
      end else begin
        want_rgb = pending_rgb.pop_front();
        if (got_rgb.red !== want_rgb.red) begin
          fail_count++;
          $display("%0t: red_level expected %h got %h", $time, want_rgb.red,
                   got_rgb.red);
        end
        if (got_rgb.green !== want_rgb.green) begin
          fail_count++;
          $display("%0t: green_level expected %h got %h", $time, want_rgb.green,
                   got_rgb.green);
        end
        if (got_rgb.blue !== want_rgb.blue) begin
          fail_count++;
          $display("%0t: blue_level expected %h got %h", $time, want_rgb.blue,
                   got_rgb.blue);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edge_hues();
    test_register_extremes();
    test_random_hues();
    // Let the pipeline settle to catch any stray beat.
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && pending_rgb.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
